// ===== rtl/core/pbfla_pkg.sv =====
// pbfla_pkg: shared widths, codes and pipeline types for the packet buffer allocator.
// No dependencies; imported by packet_buffer_free_list_allocator.
package pbfla_pkg;

  localparam int IDX_W      = 10;   // buffer index field
  localparam int ADDR_W     = 48;   // buffer address field
  localparam int SIZE_W     = 16;   // entry size register
  localparam int CNT_W      = 11;   // buffer count register
  localparam int REQ_W      = 6;    // request count field
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W     = IDX_W + SIZE_W;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOBUF  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd2048;

  // Stage 1: result as issued, index still possibly in the stack RAM read data.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              last;
    logic              pop;      // allocation grant: address is computed
    logic              use_mem;  // index comes from RAM read data
    logic [IDX_W-1:0]  idx;
  } pbfla_s1_t;

  // Stage 2: index resolved, index times entry size registered.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              last;
    logic              pop;
    logic [IDX_W-1:0]  idx;
    logic [PROD_W-1:0] prod;
  } pbfla_s2_t;

endpackage

// ===== rtl/core/packet_buffer_free_list_allocator.sv =====
// packet_buffer_free_list_allocator: buffer pool allocator built on a free-index stack in RAM.
// Depends on pbfla_pkg (widths, codes, stage types) and pbfla_ram (stack storage).
//
//   channel   handshake                  payload
//   -------   ------------------------   ---------------------------------------------
//   command   start / busy               op, request_count, free_index
//   config    cfg_valid / cfg_ready      cfg_index, cfg_data
//   result    result_valid (1-cycle)     status, buffer_index, buffer_addr, last
//
// A command transaction is taken on start & !busy. A free or an allocate on an empty pool puts
// its one result through the stage 1, stage 2 and result registers and keeps busy high until
// that result reaches the output registers; an allocate granted n buffers sets popping and pops
// one stack entry per cycle, each pop passing the same registers, and the block stays busy until
// its last result reaches the output registers. A zero request on a non-empty pool gives nothing
// and never raises busy.
// Config is ready while not busy and no start is offered, so writes never overlap a command.
// Reset (rst, synchronous) restores the registers and refills the stack without a clearing
// pass; results cannot be stalled, each is valid for exactly one cycle.
module packet_buffer_free_list_allocator #(
  parameter int POOL_DEPTH = 1024,
  parameter int MAX_BATCH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command transactions
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [pbfla_pkg::REQ_W-1:0]          request_count,
  input  logic [pbfla_pkg::IDX_W-1:0]          free_index,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbfla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbfla_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result transactions
  output logic                                 result_valid,
  output logic [pbfla_pkg::STAT_W-1:0]         status,
  output logic [pbfla_pkg::IDX_W-1:0]          buffer_index,
  output logic [pbfla_pkg::ADDR_W-1:0]         buffer_addr,
  output logic                                 last
);
  import pbfla_pkg::*;

  localparam int AW        = $clog2(POOL_DEPTH);       // stack slot address
  localparam int TW        = $clog2(POOL_DEPTH + 1);   // stack pointer, holds the depth
  localparam int BW        = $clog2(MAX_BATCH + 1);    // pops left in a batch
  localparam int RST_COUNT = (POOL_DEPTH < 1024) ? POOL_DEPTH : 1024;

  // Configuration registers
  logic [ADDR_W-1:0] base_addr;
  logic [SIZE_W-1:0] buf_stride;
  logic [TW-1:0]     count;

  // Stack control. low_mark is the lowest stack pointer seen since the last refill:
  // slots below it were never written since then, so their index is the slot number itself,
  // and the refill costs nothing and needs no RAM sweep.
  logic [TW-1:0]     top;
  logic [TW-1:0]     low_mark;
  logic              popping;
  logic [BW-1:0]     pop_left;

  // Pipeline
  logic              s1_valid;
  pbfla_s1_t         s1;
  logic              s2_valid;
  pbfla_s2_t         s2;

  logic              accept;
  logic              cfg_write;
  logic              full;
  logic              empty;
  logic [TW-1:0]     slot;
  logic [31:0]       want;
  logic [31:0]       grant;
  logic [TW-1:0]     count_clamped;
  logic [CNT_W-1:0]  count_raw;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_data;
  logic [IDX_W-1:0]  s1_idx;
  logic [PROD_W-1:0] prod_next;

  assign busy      = popping | s1_valid | s2_valid;
  assign cfg_ready = ~busy & ~start;
  assign accept    = start & ~busy;
  assign cfg_write = cfg_valid & cfg_ready;

  assign full  = (top >= count);
  assign empty = (top == '0);
  assign slot  = top - TW'(1);

  // Batch size: request limited to the batch cap and to the free entries.
  always_comb begin
    want  = (32'(request_count) > 32'(MAX_BATCH)) ? 32'(MAX_BATCH) : 32'(request_count);
    grant = (want > 32'(top)) ? 32'(top) : want;
  end

  // Buffer count write: zero becomes one, anything above the pool depth is capped.
  assign count_raw = cfg_data[CNT_W-1:0];
  always_comb begin
    if (count_raw == '0) begin
      count_clamped = TW'(1);
    end else if (32'(count_raw) > 32'(POOL_DEPTH)) begin
      count_clamped = TW'(POOL_DEPTH);
    end else begin
      count_clamped = TW'(count_raw);
    end
  end

  // Free pushes at top; pops read top-1. Both never occur in the same cycle.
  assign wr_en = accept & (op == OP_FREE) & ~full;

  pbfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (top[AW-1:0]),
    .wr_data (free_index),
    .rd_en   (popping),
    .rd_addr (slot[AW-1:0]),
    .rd_data (rd_data)
  );

  assign s1_idx    = s1.use_mem ? rd_data : s1.idx;
  assign prod_next = PROD_W'(s1_idx) * PROD_W'(buf_stride);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr    <= '0;
      buf_stride   <= SIZE_RESET;
      count        <= TW'(RST_COUNT);
      top          <= TW'(RST_COUNT);
      low_mark     <= TW'(RST_COUNT);
      popping      <= 1'b0;
      pop_left     <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= 1'b0;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;

      if (accept) begin
        if (op == OP_FREE) begin
          s1_valid <= 1'b1;
          if (!full) begin
            top <= top + TW'(1);
          end
        end else if (empty) begin
          s1_valid <= 1'b1;
        end else if (grant != '0) begin
          popping  <= 1'b1;
          pop_left <= BW'(grant);
        end
      end

      if (popping) begin
        s1_valid <= 1'b1;
        top      <= slot;
        pop_left <= pop_left - BW'(1);
        if (slot < low_mark) begin
          low_mark <= slot;
        end
        if (pop_left == BW'(1)) begin
          popping <= 1'b0;
        end
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_BASE:  base_addr  <= cfg_data[ADDR_W-1:0];
          REG_SIZE:  buf_stride <= cfg_data[SIZE_W-1:0];
          REG_COUNT: begin
            count    <= count_clamped;
            top      <= count_clamped;
            low_mark <= count_clamped;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (op == OP_FREE) begin
        s1.status  <= full ? ST_FULL : ST_OK;
        s1.idx     <= free_index;
      end else begin
        s1.status  <= ST_NOBUF;
        s1.idx     <= '0;
      end
      s1.last    <= 1'b1;
      s1.pop     <= 1'b0;
      s1.use_mem <= 1'b0;
    end
    if (popping) begin
      s1.status  <= ST_OK;
      s1.last    <= (pop_left == BW'(1));
      s1.pop     <= 1'b1;
      s1.use_mem <= (slot >= low_mark);
      s1.idx     <= IDX_W'(slot);
    end

    s2.status <= s1.status;
    s2.last   <= s1.last;
    s2.pop    <= s1.pop;
    s2.idx    <= s1_idx;
    s2.prod   <= prod_next;

    status       <= s2.status;
    buffer_index <= s2.idx;
    buffer_addr  <= s2.pop ? (base_addr + ADDR_W'(s2.prod)) : '0;
    last         <= s2.last;
  end

  // Checks
  a_top_le_count: assert property (@(posedge clk) disable iff (rst) top <= count)
    else $error("stack pointer above buffer count");

  a_mark_le_top: assert property (@(posedge clk) disable iff (rst) low_mark <= top)
    else $error("low-water mark above stack pointer");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) popping |-> top != '0)
    else $error("pop from empty stack");

  a_nobuf_result: assert property (@(posedge clk) disable iff (rst)
      (accept && op == OP_ALLOC && top == '0) |=> (s1_valid && s1.status == ST_NOBUF))
    else $error("empty allocate did not issue a no-buffer result");

endmodule

// ===== rtl/core/pbfla_ram.sv =====
// pbfla_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbfla_ram #(
  parameter int WIDTH  = 10,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
